// ===== rtl/sun_direction_from_time_assert.svh =====
// assertion macros shared by the checker
`ifndef SUN_DIRECTION_FROM_TIME_ASSERT_SVH
`define SUN_DIRECTION_FROM_TIME_ASSERT_SVH

// same-cycle implication
`define SDFT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDFT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdft_pkg.sv =====
`timescale 1ns / 1ps
package sdft_pkg;

  // field widths
  localparam int TIME_W    = 48;
  localparam int T_W       = 49;
  localparam int SPD_W     = 17;
  localparam int DPY_W     = 18;
  localparam int TILT_W    = 15;
  localparam int LAT_W     = 16;
  localparam int LON_W     = 16;
  localparam int DAYLEN_W  = SPD_W + 16;
  localparam int YEARLEN_W = SPD_W + DPY_W + 8;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // register reset values
  localparam logic [SPD_W-1:0]  SPD_RST  = 17'd86400;
  localparam logic [DPY_W-1:0]  DPY_RST  = 18'd93504;
  localparam logic [TILT_W-1:0] TILT_RST = 15'd4267;
  localparam logic [YEARLEN_W-1:0] YEAR_LEN_RST =
    (YEARLEN_W'(DPY_RST) * YEARLEN_W'(SPD_RST)) << 8;

  // day 81 in q8 days, numerator of the year phase offset
  localparam logic [T_W-1:0] OFF_NUM = 49'd20736;

  // register map
  typedef enum logic [2:0] {
    REG_SPD,
    REG_DPY,
    REG_TILT,
    REG_LAT,
    REG_LON
  } reg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [SPD_W-1:0]     d_eff;
    logic [DPY_W-1:0]     y_eff;
    logic [YEARLEN_W-1:0] year_len;
    logic [TILT_W-1:0]    tilt;
    logic [LAT_W-1:0]     lat;
    logic [LON_W-1:0]     lon;
  } sdft_cfg_t;

  // sine polynomial, q30
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [62:0] Q30_HALF = 63'h2000_0000;
  localparam logic [30:0] SIN_C11  = 31'd3864;
  typedef logic [30:0] coef_arr_t [5];
  localparam coef_arr_t HORNER_C = '{
    31'd172273, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  // q30 product rounded half up
  function automatic logic [32:0] rnd30(input logic [61:0] p);
    logic [62:0] s;
    s = 63'(p) + Q30_HALF;
    return s[62:30];
  endfunction

  // magnitude of a signed q30 value
  function automatic logic [30:0] q30_mag(input logic signed [31:0] v);
    return (v < 0) ? 31'(-v) : 31'(v);
  endfunction

endpackage

// ===== rtl/sdft_cfg.sv =====
`timescale 1ns / 1ps
module sdft_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdft_pkg::ADDR_W-1:0]   paddr,
  input  logic [sdft_pkg::DATA_W-1:0]   pwdata,
  output logic [sdft_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output sdft_pkg::sdft_cfg_t           cfg_o
);
  import sdft_pkg::*;

  logic [SPD_W-1:0]     spd_q;
  logic [DPY_W-1:0]     dpy_q;
  logic [TILT_W-1:0]    tilt_q;
  logic [LAT_W-1:0]     lat_q;
  logic [LON_W-1:0]     lon_q;
  logic [YEARLEN_W-1:0] year_len_q;
  logic [YEARLEN_W-1:0] year_len_d;
  logic [SPD_W-1:0]     d_eff;
  logic [DPY_W-1:0]     y_eff;
  reg_idx_e             idx;
  logic                 wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // zero lengths count as one
  assign d_eff = (spd_q == '0) ? SPD_W'(1) : spd_q;
  assign y_eff = (dpy_q == '0) ? DPY_W'(1) : dpy_q;
  assign year_len_d = (YEARLEN_W'(y_eff) * YEARLEN_W'(d_eff)) << 8;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_q  <= SPD_RST;
      dpy_q  <= DPY_RST;
      tilt_q <= TILT_RST;
      lat_q  <= '0;
      lon_q  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPD:  spd_q  <= pwdata[SPD_W-1:0];
        REG_DPY:  dpy_q  <= pwdata[DPY_W-1:0];
        REG_TILT: tilt_q <= pwdata[TILT_W-1:0];
        REG_LAT:  lat_q  <= pwdata[LAT_W-1:0];
        REG_LON:  lon_q  <= pwdata[LON_W-1:0];
        default: ;
      endcase
    end
  end

  // year length in 2^-16 s, follows the registers in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_len_q <= YEAR_LEN_RST;
    end else begin
      year_len_q <= year_len_d;
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_SPD:  prdata = DATA_W'(spd_q);
      REG_DPY:  prdata = DATA_W'(dpy_q);
      REG_TILT: prdata = DATA_W'(tilt_q);
      REG_LAT:  prdata = DATA_W'(lat_q);
      REG_LON:  prdata = DATA_W'(lon_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = '{
    d_eff:    d_eff,
    y_eff:    y_eff,
    year_len: year_len_q,
    tilt:     tilt_q,
    lat:      lat_q,
    lon:      lon_q
  };

endmodule

// ===== rtl/sdft_div.sv =====
`timescale 1ns / 1ps
// restoring division, one quotient bit per stage; q_o holds the low
// Q_W bits of floor(num * 2^Q_W / div)
module sdft_div #(
  parameter int NUM_W = 49,
  parameter int DIV_W = 33,
  parameter int Q_W   = 16
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0] div_i,
  output logic [Q_W-1:0]   q_o
);
  localparam int STEPS = NUM_W + Q_W;

  logic [DIV_W-1:0] rem_q [STEPS];
  logic [Q_W-1:0]   quo_q [STEPS];
  logic [NUM_W-1:0] num_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DIV_W-1:0] rem_in;
    logic [Q_W-1:0]   quo_in;
    logic [NUM_W-1:0] num_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, div_i};
    assign ge    = trial >= {1'b0, div_i};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q[k] <= {quo_in[Q_W-2:0], ge};
      num_q[k] <= num_in << 1;
    end
  end

  assign q_o = quo_q[STEPS-1];

endmodule

// ===== rtl/sdft_sin.sv =====
`timescale 1ns / 1ps
// sine of an angle in turns, q30 result, eight register stages
module sdft_sin #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic [ANGLE_BITS-1:0]   angle_i,
  output logic signed [31:0]      value_o
);
  import sdft_pkg::*;

  localparam int LOW_ZERO = 32 - ANGLE_BITS;
  localparam int HS       = 5;

  logic [29:0] frac;
  logic [30:0] t_in;
  logic        neg_in;
  logic [32:0] t2_rnd;
  logic [32:0] s_rnd;
  logic [30:0] s_sat;

  logic [30:0] t_q   [HS+2];
  logic        neg_q [HS+2];
  logic [61:0] p_q   [HS+2];
  logic [30:0] t2_q  [1:HS];
  logic signed [31:0] value_q;

  // fold into a quarter turn
  assign frac   = {angle_i[ANGLE_BITS-3:0], {LOW_ZERO{1'b0}}};
  assign neg_in = angle_i[ANGLE_BITS-1];
  assign t_in   = angle_i[ANGLE_BITS-2] ? (Q30_ONE - {1'b0, frac}) : {1'b0, frac};

  // t squared
  always_ff @(posedge clk_i) begin
    t_q[0]   <= t_in;
    neg_q[0] <= neg_in;
    p_q[0]   <= 62'(t_in) * 62'(t_in);
  end

  // first horner product
  assign t2_rnd = rnd30(p_q[0]);
  always_ff @(posedge clk_i) begin
    t_q[1]   <= t_q[0];
    neg_q[1] <= neg_q[0];
    t2_q[1]  <= t2_rnd[30:0];
    p_q[1]   <= 62'(t2_rnd[30:0]) * 62'(SIN_C11);
  end

  // horner steps, last one multiplies by t
  for (genvar k = 0; k < HS; k++) begin : g_horner
    logic [32:0] r_full;
    logic [30:0] r;
    logic [30:0] mul;

    assign r_full = 33'(HORNER_C[k]) - rnd30(p_q[k+1]);
    assign r      = r_full[30:0];

    if (k < HS - 1) begin : g_t2
      assign mul = t2_q[k+1];
      always_ff @(posedge clk_i) begin
        t2_q[k+2] <= t2_q[k+1];
      end
    end else begin : g_t
      assign mul = t_q[k+1];
    end

    always_ff @(posedge clk_i) begin
      t_q[k+2]   <= t_q[k+1];
      neg_q[k+2] <= neg_q[k+1];
      p_q[k+2]   <= 62'(mul) * 62'(r);
    end
  end

  // clamp to one and apply the half-turn sign
  assign s_rnd = rnd30(p_q[HS+1]);
  assign s_sat = (s_rnd > 33'(Q30_ONE)) ? Q30_ONE : s_rnd[30:0];

  always_ff @(posedge clk_i) begin
    value_q <= neg_q[HS+1] ? -$signed({1'b0, s_sat}) : $signed({1'b0, s_sat});
  end

  assign value_o = value_q;

endmodule

// ===== rtl/sun_direction_from_time.sv =====
`timescale 1ns / 1ps
// channel   direction  signals                                 transfer when
// command   in         start, busy, time_seconds_i             start && !busy
// result    out        done_o, dir_x_o, dir_y_o, dir_z_o       done_o (one cycle)
// config    in/out     psel, penable, pwrite, paddr, pwdata,   psel && penable
//                      prdata, pready                          && pwrite
//
// one timestamp per cycle; busy is never raised
// the day and year long divisions take one quotient bit per stage over
// 49 + ANGLE_BITS stages
// reset clears the valid pipeline and loads the register defaults
// results leave on done_o in the cycle they are ready; the receiver cannot stall
module sun_direction_from_time #(
  parameter int ANGLE_BITS = 16,
  parameter int OUT_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sdft_pkg::TIME_W-1:0]   time_seconds_i,
  output logic                          done_o,
  output logic signed [OUT_BITS-1:0]    dir_x_o,
  output logic signed [OUT_BITS-1:0]    dir_y_o,
  output logic signed [OUT_BITS-1:0]    dir_z_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdft_pkg::ADDR_W-1:0]   paddr,
  input  logic [sdft_pkg::DATA_W-1:0]   pwdata,
  output logic [sdft_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import sdft_pkg::*;

  localparam int STEPS   = T_W + ANGLE_BITS;
  localparam int VLD_LEN = STEPS + 24;
  localparam int LATENCY = VLD_LEN;
  localparam int HA_DLY  = 10;
  localparam int SH      = 31 - OUT_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [33:0] RND_OUT = 34'(1) << (SH - 1);
  localparam logic [33:0] MAXV    = (34'(1) << (OUT_BITS - 1)) - 34'(1);

  sdft_cfg_t cfg;
  logic      accept;

  logic [VLD_LEN-1:0] vld_q;
  logic [T_W-1:0]     t_q;
  logic [DAYLEN_W-1:0] day_len;
  logic [ANGLE_BITS-1:0] day_ph, year_ph, off_ph;
  logic [31:0] lat_ph32, lon_ph32;
  logic [ANGLE_BITS-1:0] lat_a, lon_a;
  logic [ANGLE_BITS-1:0] ha_q, yph_q, dec_q;
  logic [ANGLE_BITS-1:0] ha_dly_q [HA_DLY];
  logic signed [31:0] sy, sd, cd, sh, ch, sl, cl;
  logic [45:0] mag_prod_q;
  logic        sy_neg_q;
  logic [45:0] mag_sum;
  logic [31:0] mag32, dec32;

  logic [61:0] m1_q, m2_q, m3_q, m4_q, m5_q, m6_q;
  logic        s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic [30:0] cl_mag_q, sl_mag_q;
  logic        cl_neg_q, sl_neg_q;
  logic [32:0] cdch_rnd;
  logic signed [33:0] x_q, a_q, b_q, x2_q, y_q, z_q;
  logic signed [OUT_BITS-1:0] dx_q, dy_q, dz_q;

  // signed value from sign and magnitude
  function automatic logic signed [33:0] with_sign(input logic neg, input logic [32:0] m);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // q30 to output width, half away from zero, saturated
  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] r;
    m = (v < 0) ? 34'(-v) : 34'(v);
    r = (m + RND_OUT) >> SH;
    if (r > MAXV) begin
      r = MAXV;
    end
    return (v < 0) ? OUT_BITS'(-r) : OUT_BITS'(r);
  endfunction

  sdft_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_LEN-2:0], accept};
    end
  end

  // time shifted by a quarter day
  always_ff @(posedge clk_i) begin
    t_q <= T_W'(time_seconds_i) + (T_W'(cfg.d_eff) << 14);
  end

  assign day_len = {cfg.d_eff, 16'b0};

  // day fraction, year fraction and day 81 offset
  sdft_div #(.NUM_W(T_W), .DIV_W(DAYLEN_W), .Q_W(ANGLE_BITS)) u_div_day (
    .clk_i (clk_i),
    .num_i (t_q),
    .div_i (day_len),
    .q_o   (day_ph)
  );

  sdft_div #(.NUM_W(T_W), .DIV_W(YEARLEN_W), .Q_W(ANGLE_BITS)) u_div_year (
    .clk_i (clk_i),
    .num_i (t_q),
    .div_i (cfg.year_len),
    .q_o   (year_ph)
  );

  sdft_div #(.NUM_W(T_W), .DIV_W(DPY_W), .Q_W(ANGLE_BITS)) u_div_off (
    .clk_i (clk_i),
    .num_i (OFF_NUM),
    .div_i (cfg.y_eff),
    .q_o   (off_ph)
  );

  // register angles truncated to the phase width
  assign lat_ph32 = {cfg.lat, 16'b0};
  assign lon_ph32 = {cfg.lon, 16'b0};
  assign lat_a    = lat_ph32[31 -: ANGLE_BITS];
  assign lon_a    = lon_ph32[31 -: ANGLE_BITS];

  // hour angle and year phase
  always_ff @(posedge clk_i) begin
    ha_q  <= day_ph + lon_a + HALF;
    yph_q <= year_ph - off_ph;
  end

  // hour angle waits for the declination
  always_ff @(posedge clk_i) begin
    ha_dly_q[0] <= ha_q;
    for (int i = 1; i < HA_DLY; i++) begin
      ha_dly_q[i] <= ha_dly_q[i-1];
    end
  end

  sdft_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_year (
    .clk_i (clk_i), .angle_i (yph_q), .value_o (sy)
  );

  // declination magnitude
  always_ff @(posedge clk_i) begin
    mag_prod_q <= 46'(cfg.tilt) * 46'(q30_mag(sy));
    sy_neg_q   <= sy < 0;
  end

  assign mag_sum = mag_prod_q + 46'h2000;
  assign mag32   = mag_sum[45:14];
  assign dec32   = sy_neg_q ? (32'd0 - mag32) : mag32;

  always_ff @(posedge clk_i) begin
    dec_q <= dec32[31 -: ANGLE_BITS];
  end

  // sines and cosines
  sdft_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_dec (
    .clk_i (clk_i), .angle_i (dec_q), .value_o (sd)
  );
  sdft_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_dec (
    .clk_i (clk_i), .angle_i (dec_q + QUARTER), .value_o (cd)
  );
  sdft_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ha (
    .clk_i (clk_i), .angle_i (ha_dly_q[HA_DLY-1]), .value_o (sh)
  );
  sdft_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ha (
    .clk_i (clk_i), .angle_i (ha_dly_q[HA_DLY-1] + QUARTER), .value_o (ch)
  );
  sdft_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_lat (
    .clk_i (clk_i), .angle_i (lat_a), .value_o (sl)
  );
  sdft_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_lat (
    .clk_i (clk_i), .angle_i (lat_a + QUARTER), .value_o (cl)
  );

  // first products on magnitudes
  always_ff @(posedge clk_i) begin
    m1_q     <= 62'(q30_mag(cd)) * 62'(q30_mag(ch));
    s1_q     <= (cd < 0) ^ (ch < 0);
    m2_q     <= 62'(q30_mag(cd)) * 62'(q30_mag(sh));
    s2_q     <= (cd < 0) ^ (sh < 0);
    m3_q     <= 62'(q30_mag(sl)) * 62'(q30_mag(sd));
    s3_q     <= (sl < 0) ^ (sd < 0);
    m4_q     <= 62'(q30_mag(cl)) * 62'(q30_mag(sd));
    s4_q     <= (cl < 0) ^ (sd < 0);
    cl_mag_q <= q30_mag(cl);
    sl_mag_q <= q30_mag(sl);
    cl_neg_q <= cl < 0;
    sl_neg_q <= sl < 0;
  end

  // round, then latitude times the hour term
  assign cdch_rnd = rnd30(m1_q);

  always_ff @(posedge clk_i) begin
    x_q  <= with_sign(s2_q, rnd30(m2_q));
    a_q  <= with_sign(s3_q, rnd30(m3_q));
    b_q  <= with_sign(s4_q, rnd30(m4_q));
    m5_q <= 62'(cl_mag_q) * 62'(cdch_rnd[30:0]);
    s5_q <= cl_neg_q ^ s1_q;
    m6_q <= 62'(sl_mag_q) * 62'(cdch_rnd[30:0]);
    s6_q <= sl_neg_q ^ s1_q;
  end

  // vector sums
  always_ff @(posedge clk_i) begin
    x2_q <= x_q;
    y_q  <= a_q + with_sign(s5_q, rnd30(m5_q));
    z_q  <= b_q - with_sign(s6_q, rnd30(m6_q));
  end

  // output scaling
  always_ff @(posedge clk_i) begin
    dx_q <= to_out(x2_q);
    dy_q <= to_out(y_q);
    dz_q <= to_out(z_q);
  end

  assign done_o  = vld_q[VLD_LEN-1];
  assign dir_x_o = dx_q;
  assign dir_y_o = dy_q;
  assign dir_z_o = dz_q;

endmodule

// ===== rtl/sdft_checker.sv =====
`timescale 1ns / 1ps
`include "sun_direction_from_time_assert.svh"
module sdft_checker #(
  parameter int LATENCY  = 89,
  parameter int OUT_BITS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [OUT_BITS-1:0] dir_x_o,
  input logic [OUT_BITS-1:0] dir_y_o,
  input logic [OUT_BITS-1:0] dir_z_o,
  input logic                pready
);
  localparam logic [OUT_BITS-1:0] MINV = {1'b1, {(OUT_BITS-1){1'b0}}};

  // saturation never yields the most negative code
  `SDFT_ASSERT_IMP(a_sat, clk_i, rst_ni, done_o,
    dir_x_o != MINV && dir_y_o != MINV && dir_z_o != MINV, "output not saturated")

  // every result comes from a transfer a fixed latency earlier
  `SDFT_ASSERT_IMP(a_lat, clk_i, rst_ni, done_o,
    $past(start && !busy, LATENCY), "result without a matching command")

  // commands may follow back to back
  `SDFT_ASSERT_NXT(a_b2b, clk_i, rst_ni, start && !busy, !busy, "busy after a command")

  // register port never waits
  `SDFT_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready, "pready low")

endmodule

bind sun_direction_from_time sdft_checker #(
  .LATENCY  (LATENCY),
  .OUT_BITS (OUT_BITS)
) u_sdft_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .dir_x_o (dir_x_o),
  .dir_y_o (dir_y_o),
  .dir_z_o (dir_z_o),
  .pready  (pready)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sdft_pkg::*;

  localparam int LATENCY = 89;
  localparam int STALL_LIMIT = 4000;
  localparam int N_ITEMS = 1300;

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_SPD  = ADDR_W'(4 * REG_SPD);
  localparam logic [ADDR_W-1:0] ADDR_DPY  = ADDR_W'(4 * REG_DPY);
  localparam logic [ADDR_W-1:0] ADDR_TILT = ADDR_W'(4 * REG_TILT);
  localparam logic [ADDR_W-1:0] ADDR_LAT  = ADDR_W'(4 * REG_LAT);
  localparam logic [ADDR_W-1:0] ADDR_LON  = ADDR_W'(4 * REG_LON);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sun_dir_t;

  typedef struct {
    logic [TIME_W-1:0] stamp;
    bit                typed;
    sun_dir_t          dir;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TIME_W-1:0] time_seconds_i = '0;
  logic done_o;
  logic signed [15:0] dir_x_o, dir_y_o, dir_z_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sun_direction_from_time dut (
    .clk_i, .rst_ni, .start, .busy, .time_seconds_i,
    .done_o, .dir_x_o, .dir_y_o, .dir_z_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [16:0] day_secs = 17'd86400;
  logic [17:0] year_days_q8 = 18'd93504;
  logic [14:0] tilt_ang = 15'd4267;
  logic [15:0] lat_ang = '0;
  logic [15:0] lon_ang = '0;

  sun_dir_t expected_dirs[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int idle_pct = 0;
  bit next_typed = 1'b0;
  sun_dir_t next_typed_dir;

  function automatic logic [31:0] frac_turn(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    logic [31:0] q;
    rem = num;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q << 16;
  endfunction

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b + 64'h2000_0000) >> 30;
  endfunction

  function automatic longint signed sine_q30(logic [31:0] p);
    longint unsigned t, t2, r, s;
    t = p[29:0];
    if (p[30]) t = 64'h4000_0000 - t;
    t2 = mul_q30(t, t);
    r = 64'd172273 - mul_q30(t2, 64'd3864);
    r = 64'd5026995 - mul_q30(t2, r);
    r = 64'd85569306 - mul_q30(t2, r);
    r = 64'd693598668 - mul_q30(t2, r);
    r = 64'd1686629713 - mul_q30(t2, r);
    s = mul_q30(t, r);
    if (s > 64'h4000_0000) s = 64'h4000_0000;
    return p[31] ? -longint'(s) : longint'(s);
  endfunction

  // signed q30 product, rounded half away from zero
  function automatic longint signed smul_q30(longint signed a, longint signed b);
    longint unsigned ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m = (ua * ub + 64'h2000_0000) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [15:0] to_q15(longint signed v);
    longint unsigned m, r;
    m = (v < 0) ? -v : v;
    r = (m + 64'h4000) >> 15;
    if (r > 32767) r = 32767;
    return (v < 0) ? -16'(r) : 16'(r);
  endfunction

  function automatic sun_dir_t sun_direction(logic [TIME_W-1:0] stamp);
    longint unsigned d, y, day_len, year_len, t, off, mag;
    logic [31:0] day_ph, year_ph, off_ph, lat, lon, ha, dec;
    longint signed sy, sd, cd, sh, ch, sl, cl, cdch;
    sun_dir_t r;
    d = (day_secs == 0) ? 1 : day_secs;
    y = (year_days_q8 == 0) ? 1 : year_days_q8;
    day_len = d << 16;
    year_len = y * d * 256;
    t = longint'(stamp) + (d << 14);
    day_ph = frac_turn(t % day_len, day_len);
    year_ph = frac_turn(t % year_len, year_len);
    off = ((64'd81 * 256) << 16) / y;
    off_ph = 32'(off << 16);
    lat = {lat_ang, 16'h0};
    lon = {lon_ang, 16'h0};
    ha = (day_ph + lon + 32'h8000_0000) & 32'hFFFF_0000;
    sy = sine_q30((year_ph - off_ph) & 32'hFFFF_0000);
    mag = (longint'(tilt_ang) * ((sy < 0) ? -sy : sy) + 64'h2000) >> 14;
    dec = 32'(mag);
    if (sy < 0) dec = -dec;
    dec = dec & 32'hFFFF_0000;
    sd = sine_q30(dec);
    cd = sine_q30(dec + 32'h4000_0000);
    sh = sine_q30(ha);
    ch = sine_q30(ha + 32'h4000_0000);
    sl = sine_q30(lat);
    cl = sine_q30(lat + 32'h4000_0000);
    cdch = smul_q30(cd, ch);
    r.x = to_q15(smul_q30(cd, sh));
    r.y = to_q15(smul_q30(sl, sd) + smul_q30(cl, cdch));
    r.z = to_q15(smul_q30(cl, sd) - smul_q30(sl, cdch));
    return r;
  endfunction

  // transfer monitor, result checker and watchdog
  always @(posedge clk_i) begin
    sun_dir_t want, got;
    bit seen;
    seen = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        seen = 1'b1;
        expected_dirs.push_back(next_typed ? next_typed_dir : sun_direction(time_seconds_i));
      end
      if (done_o) begin
        seen = 1'b1;
        got = '{dir_x_o, dir_y_o, dir_z_o};
        if (expected_dirs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d %0d %0d", got.x, got.y, got.z);
        end else begin
          want = expected_dirs.pop_front();
          if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("dir mismatch: exp %0d %0d %0d got %0d %0d %0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
          end
        end
      end
      idle_cycles <= seen ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (addr)
      ADDR_SPD:  day_secs = data[16:0];
      ADDR_DPY:  year_days_q8 = data[17:0];
      ADDR_TILT: tilt_ang = data[14:0];
      ADDR_LAT:  lat_ang = data[15:0];
      ADDR_LON:  lon_ang = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apb_check_read(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] want);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("reg %0d read: exp %0h got %0h", addr, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every expected result, plus pipeline drain
  task automatic drain();
    while (expected_dirs.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // one command transfer, each cycle ahead of it idle with the set odds
  task automatic send_time(logic [TIME_W-1:0] stamp, bit typed, sun_dir_t dir);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    time_seconds_i <= stamp;
    next_typed <= typed;
    next_typed_dir <= dir;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    next_typed <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    logic [TIME_W-1:0] v;
    v = TIME_W'({$urandom, $urandom});
    case ($urandom_range(3))
      0: return v;
      1: return v & 48'h0000_FFFF_FFFF;
      2: return TIME_W'(day_secs) * 65536 * $urandom_range(0, 2000)
                + TIME_W'($urandom_range(0, 7)) - 4;
      default: return v >> $urandom_range(0, 47);
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{48'd0, 1'b1, '{-16'sd32767, 16'sd0, 16'sd0}},
    '{48'd86400 << 14, 1'b1, '{16'sd0, 16'sd32767, 16'sd0}},
    '{48'd1, 1'b0, '0},
    '{48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{48'h8000_0000_0000, 1'b0, '0},
    '{48'h5555_5555_5555, 1'b0, '0},
    '{48'hAAAA_AAAA_AAAA, 1'b0, '0},
    '{48'd86400 << 16, 1'b0, '0},
    '{(48'd86400 << 16) - 1, 1'b0, '0},
    '{48'd86400 * 81 << 16, 1'b0, '0},
    '{48'd86400 * 365 << 16, 1'b0, '0},
    '{48'd86400 * 365 * 100 << 16, 1'b0, '0}
  };

  // register settings per phase: spd, dpy, tilt, lat, lon
  logic [DATA_W-1:0] settings[][5] = '{
    '{32'd86400, 32'd93504, 32'd4267, 32'd0, 32'd0},
    '{32'd1, 32'd256, 32'd16384, 32'd16384, 32'h7FFF},
    '{32'd131071, 32'd262143, 32'd0, 32'hFFFF_C000, 32'hFFFF_8000},
    '{32'd0, 32'd0, 32'd32767, 32'h0000_8000, 32'h1234},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'd60, 32'd1000, 32'd4000, 32'hFFFF_E000, 32'd8192}
  };
  int idle_pcts[] = '{0, 72, 38, 0, 72, 38};

  initial begin
    sun_dir_t none;
    none = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the register file
    apb_check_read(ADDR_SPD, 32'd86400);
    apb_check_read(ADDR_DPY, 32'd93504);
    apb_check_read(ADDR_TILT, 32'd4267);
    apb_check_read(ADDR_LAT, 32'd0);
    apb_check_read(ADDR_LON, 32'd0);

    // directed rows with zero tilt, then two bad register indices and the untyped rows again
    apb_write(ADDR_TILT, 32'd0);
    foreach (directed[i]) send_time(directed[i].stamp, directed[i].typed, directed[i].dir);
    stop_sending();
    drain();
    apb_write(ADDR_W'(20), 32'hFFFF_FFFF);
    apb_write(ADDR_W'(28), 32'h0);
    apb_write(ADDR_TILT, 32'd4267);
    foreach (directed[i]) if (!directed[i].typed) send_time(directed[i].stamp, 1'b0, none);
    stop_sending();

    // random phases across register settings
    foreach (settings[p]) begin
      drain();
      apb_write(ADDR_SPD, settings[p][0]);
      apb_write(ADDR_DPY, settings[p][1]);
      apb_write(ADDR_TILT, settings[p][2]);
      apb_write(ADDR_LAT, settings[p][3]);
      apb_write(ADDR_LON, settings[p][4]);
      idle_pct = idle_pcts[p];
      for (int i = 0; i < N_ITEMS / 8; i++) send_time(random_time(), 1'b0, none);
      stop_sending();
    end

    // random registers as well
    repeat (4) begin
      drain();
      apb_write(ADDR_SPD, $urandom);
      apb_write(ADDR_DPY, $urandom);
      apb_write(ADDR_TILT, $urandom);
      apb_write(ADDR_LAT, $urandom);
      apb_write(ADDR_LON, $urandom);
      idle_pct = $urandom_range(0, 72);
      for (int i = 0; i < N_ITEMS / 16; i++) send_time(random_time(), 1'b0, none);
      stop_sending();
    end

    drain();
    if (mismatches == 0 && expected_dirs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
